/* rtl/core/amebs_pkg.sv */
// ---------------------------------------------------------------------------
// AM envelope smoother package
// Shared types, register indexes and fixed widths of the envelope block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package amebs_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 16;
  localparam int FMAG_W     = 18;
  localparam int LEVEL_W    = 17;
  localparam int INDEX_BITS = 48;

  // Coefficient fraction bits of the biquad.
  localparam int COEF_FRAC_BITS = 16;

  // Default depth of the queue between the front and the back end.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_BP_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECIM_RATIO   = 3'd4;

  // Configuration registers as seen by the back end.
  typedef struct packed {
    logic        [16:0] bp_gain;
    logic signed [17:0] fb_coef_one;
    logic        [16:0] fb_coef_two;
    logic        [15:0] smooth_weight;
    logic        [15:0] decim_ratio;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    bp_gain:       17'd844,
    fb_coef_one:   -18'sd128275,
    fb_coef_two:   17'd63847,
    smooth_weight: 16'd1311,
    decim_ratio:   16'd48
  };

endpackage

`default_nettype wire

/* rtl/core/amebs_if.sv */
// ---------------------------------------------------------------------------
// AM envelope smoother channels
// Valid/ready channels for I/Q requests and for envelope results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface amebs_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [amebs_pkg::SAMPLE_W-1:0] i_sample;
  logic signed [amebs_pkg::SAMPLE_W-1:0] q_sample;

  modport source (output valid, output i_sample, output q_sample, input ready);
  modport sink   (input valid, input i_sample, input q_sample, output ready);
endinterface

interface amebs_out_if;
  logic                              valid;
  logic                              ready;
  logic [amebs_pkg::INDEX_BITS-1:0]  sample_index;
  logic [amebs_pkg::MAG_W-1:0]       magnitude;
  logic [amebs_pkg::FMAG_W-1:0]      filtered_magnitude;
  logic [amebs_pkg::LEVEL_W-1:0]     smoothed_level;

  modport source (output valid, output sample_index, output magnitude,
                  output filtered_magnitude, output smoothed_level, input ready);
  modport sink   (input valid, input sample_index, input magnitude,
                  input filtered_magnitude, input smoothed_level, output ready);
endinterface

`default_nettype wire

/* rtl/core/am_envelope_bandpass_smoother_top.sv */
// Throughput is set by the bit-serial square root in the front end, which
// takes no new I/Q request until its magnitude is pushed; the back end works
// each sample through its one shared multiplier, and a short queue decouples
// the two.
// Reset: synchronous, active low; filter state, counters and queue clear and
// the configuration registers return to their default coefficients.
// ---------------------------------------------------------------------------
// AM envelope bandpass smoother top level
// Magnitude, bandpass biquad, exponential averager and decimator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module am_envelope_bandpass_smoother_top #(
  parameter int QUEUE_DEPTH = amebs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  amebs_in_if.sink                             in_chan,
  amebs_out_if.source                          out_chan,
  input  wire logic                            cfg_we,
  input  wire logic [amebs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [amebs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import amebs_pkg::*;

  cfg_t             cfg_r;
  logic             q_push, q_full, q_pop, q_not_empty;
  logic [MAG_W-1:0] q_push_data, q_pop_data;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BP_GAIN:       cfg_r.bp_gain       <= cfg_wdata[16:0];
        REG_FB_COEF_ONE:   cfg_r.fb_coef_one   <= cfg_wdata;
        REG_FB_COEF_TWO:   cfg_r.fb_coef_two   <= cfg_wdata[16:0];
        REG_SMOOTH_WEIGHT: cfg_r.smooth_weight <= cfg_wdata[15:0];
        REG_DECIM_RATIO:   cfg_r.decim_ratio   <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: accept and take the magnitude.
  amebs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_i_sample (in_chan.i_sample),
    .in_q_sample (in_chan.q_sample),
    .push        (q_push),
    .push_data   (q_push_data),
    .full        (q_full)
  );

  // Magnitude queue.
  amebs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty)
  );

  // Back end: filter, smooth, decimate.
  amebs_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg                    (cfg_r),
    .q_not_empty            (q_not_empty),
    .q_data                 (q_pop_data),
    .q_pop                  (q_pop),
    .out_valid              (out_chan.valid),
    .out_ready              (out_chan.ready),
    .out_sample_index       (out_chan.sample_index),
    .out_magnitude          (out_chan.magnitude),
    .out_filtered_magnitude (out_chan.filtered_magnitude),
    .out_smoothed_level     (out_chan.smoothed_level)
  );

endmodule

`default_nettype wire

/* rtl/core/amebs_front.sv */
// ---------------------------------------------------------------------------
// AM envelope smoother front end
// Accepts I/Q requests, forms I*I+Q*Q and takes its integer square root
// one result bit per cycle, then hands the magnitude to the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amebs_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [amebs_pkg::SAMPLE_W-1:0] in_i_sample,
  input  wire logic signed [amebs_pkg::SAMPLE_W-1:0] in_q_sample,
  output logic                             push,
  output logic [amebs_pkg::MAG_W-1:0]      push_data,
  input  wire logic                        full
);
  import amebs_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_SQ_I = 3'd1;
  localparam logic [2:0] F_SQ_Q = 3'd2;
  localparam logic [2:0] F_ROOT = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  logic signed [SAMPLE_W-1:0] xi_r, xq_r;
  logic [31:0]                pw_r;
  logic [19:0]                rem_r;
  logic [MAG_W-1:0]           root_r;
  logic [3:0]                 step_r;

  logic signed [SAMPLE_W-1:0] sq_op;
  logic signed [31:0]         sq_p;
  logic [19:0]                rem_sh;
  logic [19:0]                trial;

  // One shared squarer for both components.
  assign sq_op = (state_r == F_SQ_I) ? xi_r : xq_r;
  assign sq_p  = sq_op * sq_op;

  // Square root step: bring in two bits of the power, try root*4+1.
  assign rem_sh = {rem_r[17:0], pw_r[31:30]};
  assign trial  = {2'b00, root_r, 2'b01};

  assign in_ready  = (state_r == F_IDLE);
  assign push      = (state_r == F_PUSH);
  assign push_data = root_r;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_SQ_I;
      F_SQ_I: state_nxt = F_SQ_Q;
      F_SQ_Q: state_nxt = F_ROOT;
      F_ROOT: if (step_r == 4'd0) state_nxt = F_PUSH;
      F_PUSH: if (!full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        xi_r <= in_i_sample;
        xq_r <= in_q_sample;
      end
      F_SQ_I: begin
        pw_r <= sq_p;
      end
      F_SQ_Q: begin
        pw_r   <= pw_r + 32'(sq_p);
        rem_r  <= '0;
        root_r <= '0;
        step_r <= 4'd15;
      end
      F_ROOT: begin
        pw_r   <= {pw_r[29:0], 2'b00};
        step_r <= step_r - 4'd1;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[MAG_W-2:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/amebs_queue.sv */
// ---------------------------------------------------------------------------
// AM envelope smoother queue
// Small FIFO of magnitudes between the front end and the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amebs_queue #(
  parameter int DEPTH = amebs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire logic [amebs_pkg::MAG_W-1:0] push_data,
  output logic                        full,
  input  wire logic                   pop,
  output logic [amebs_pkg::MAG_W-1:0] pop_data,
  output logic                        not_empty
);
  import amebs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [MAG_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/amebs_back.sv */
// ---------------------------------------------------------------------------
// AM envelope smoother back end
// Runs each magnitude through the bandpass biquad and the exponential
// averager on one shared multiplier, decimates and registers the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module amebs_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire amebs_pkg::cfg_t             cfg,
  input  wire logic                        q_not_empty,
  input  wire logic [amebs_pkg::MAG_W-1:0] q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [amebs_pkg::INDEX_BITS-1:0] out_sample_index,
  output logic [amebs_pkg::MAG_W-1:0]      out_magnitude,
  output logic [amebs_pkg::FMAG_W-1:0]     out_filtered_magnitude,
  output logic [amebs_pkg::LEVEL_W-1:0]    out_smoothed_level
);
  import amebs_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_M0   = 3'd1;
  localparam logic [2:0] B_M1   = 3'd2;
  localparam logic [2:0] B_M2   = 3'd3;
  localparam logic [2:0] B_RND  = 3'd4;
  localparam logic [2:0] B_S0   = 3'd5;
  localparam logic [2:0] B_S1   = 3'd6;
  localparam logic [2:0] B_OUT  = 3'd7;

  localparam logic signed [39:0] RND_HALF = 40'sd1 <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [39:0] Y_HI     = 40'sd131071;
  localparam logic signed [39:0] Y_LO     = -40'sd131072;

  logic [2:0]             state_r, state_nxt;
  logic [MAG_W-1:0]       mag_r;
  logic [16:0]            x1_r, x2_r;
  logic signed [17:0]     y1_r, y2_r;
  logic signed [39:0]     acc_r;
  logic [FMAG_W-1:0]      fmag_r;
  logic signed [34:0]     d_r;
  logic signed [37:0]     sm_r;
  logic [32:0]            accs_r;
  logic [15:0]            dc_r;
  logic [INDEX_BITS-1:0]  smp_cnt_r, idx_r;
  logic                   emit_r;
  logic                   out_valid_r;

  logic signed [18:0]     mul_a, mul_b;
  logic signed [37:0]     mul_p;
  logic signed [39:0]     prod_ext;
  logic signed [18:0]     x_diff;
  logic signed [39:0]     rnd_sum, y_wide;
  logic signed [17:0]     y_sat;
  logic signed [18:0]     y_ext;
  logic [FMAG_W-1:0]      y_abs;
  logic [15:0]            dc_inc;
  logic                   slot_free;

  // b0*x - b0*x2 is taken as one product of b0 and the difference.
  assign x_diff = $signed({3'b000, mag_r}) - $signed({2'b00, x2_r});

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      B_M0: begin
        mul_a = $signed({2'b00, cfg.bp_gain});
        mul_b = x_diff;
      end
      B_M1: begin
        mul_a = {cfg.fb_coef_one[17], cfg.fb_coef_one};
        mul_b = {y1_r[17], y1_r};
      end
      B_M2: begin
        mul_a = $signed({2'b00, cfg.fb_coef_two});
        mul_b = {y2_r[17], y2_r};
      end
      B_S0: begin
        mul_a = $signed({3'b000, cfg.smooth_weight});
        mul_b = d_r[34:16];
      end
      B_S1: begin
        mul_a = $signed({3'b000, cfg.smooth_weight});
        mul_b = $signed({3'b000, d_r[15:0]});
      end
      default: begin
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = {{2{mul_p[37]}}, mul_p};

  // Rounding, saturation and absolute value of the biquad output.
  assign rnd_sum = acc_r + RND_HALF;
  assign y_wide  = rnd_sum >>> COEF_FRAC_BITS;
  always_comb begin
    if (y_wide > Y_HI) begin
      y_sat = 18'sd131071;
    end else if (y_wide < Y_LO) begin
      y_sat = -18'sd131072;
    end else begin
      y_sat = y_wide[17:0];
    end
  end
  assign y_ext = {y_sat[17], y_sat};
  assign y_abs = y_ext[18] ? FMAG_W'(-y_ext) : FMAG_W'(y_ext);

  // Decimation test.
  assign dc_inc = dc_r + 16'd1;

  // The output register can take a result when empty or being drained.
  assign slot_free = !out_valid_r || out_ready;

  assign q_pop     = (state_r == B_IDLE) && q_not_empty;
  assign out_valid = out_valid_r;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (q_not_empty) state_nxt = B_M0;
      B_M0:   state_nxt = B_M1;
      B_M1:   state_nxt = B_M2;
      B_M2:   state_nxt = B_RND;
      B_RND:  state_nxt = B_S0;
      B_S0:   state_nxt = B_S1;
      B_S1:   state_nxt = B_OUT;
      B_OUT:  if (!emit_r || slot_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      x1_r        <= '0;
      x2_r        <= '0;
      y1_r        <= '0;
      y2_r        <= '0;
      accs_r      <= '0;
      dc_r        <= '0;
      smp_cnt_r   <= '0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        B_RND: begin
          x1_r <= {1'b0, mag_r};
          x2_r <= x1_r;
          y1_r <= y_sat;
          y2_r <= y1_r;
        end
        B_S1: begin
          accs_r    <= accs_r + sm_r[32:0] + {17'd0, mul_p[31:16]};
          smp_cnt_r <= smp_cnt_r + INDEX_BITS'(1);
          if ((dc_inc >= cfg.decim_ratio) || (dc_inc == 16'd0)) begin
            emit_r <= 1'b1;
            dc_r   <= '0;
          end else begin
            emit_r <= 1'b0;
            dc_r   <= dc_inc;
          end
        end
        default: begin
        end
      endcase

      // Output register: load a result, or drop the one just taken.
      if ((state_r == B_OUT) && emit_r && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: mag_r <= q_data;
      B_M0:   acc_r <= prod_ext;
      B_M1:   acc_r <= acc_r - prod_ext;
      B_M2:   acc_r <= acc_r - prod_ext;
      B_RND: begin
        fmag_r <= y_abs;
        d_r    <= $signed({1'b0, y_abs, 16'd0}) - $signed({2'b00, accs_r});
      end
      B_S0:   sm_r  <= mul_p;
      B_S1:   idx_r <= smp_cnt_r;
      default: begin
      end
    endcase

    if ((state_r == B_OUT) && emit_r && slot_free) begin
      out_sample_index       <= idx_r;
      out_magnitude          <= mag_r;
      out_filtered_magnitude <= fmag_r;
      out_smoothed_level     <= accs_r[32:16];
    end
  end

endmodule

`default_nettype wire
